### rtl/hkr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared types and constants of the hinted key registry table.
// ----------------------------------------------------------------------------
package hkr_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int REQ_W    = 2;
    localparam int IN_KEY_W = 32;
    localparam int HINT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_PRUNE  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PRUNE,
        S_FINISH
    } state_t;

endpackage
`default_nettype wire

### rtl/hinted_key_registry_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hinted_key_registry_table
// Keyed slot table with append, hinted downward search, remove and compaction.
// ----------------------------------------------------------------------------
// Keys and valid marks share one simple dual-port memory with a registered
// read, scanned at one slot per cycle. A lookup or remove searches downward
// from start, where start is min(hint, count-1), until a hit or slot 0. A
// prune reads every slot in use once. On an empty table a lookup, remove or
// prune finishes without reading the memory. A new request is taken while
// the previous result still waits in the output register. Slots at or above
// the count are never read, so the memory needs no clearing after reset.
module hinted_key_registry_table #(
    parameter int TABLE_DEPTH = hkr_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = hkr_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [hkr_pkg::REQ_W-1:0]     s_req_type,
    input  wire logic [hkr_pkg::IN_KEY_W-1:0]  s_item_key,
    input  wire logic [hkr_pkg::HINT_W-1:0]    s_slot_hint,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [hkr_pkg::STATUS_W-1:0]       m_status,
    output logic [hkr_pkg::SLOT_W-1:0]         m_slot_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = (CW > hkr_pkg::HINT_W) ? CW : hkr_pkg::HINT_W;

    logic [KEY_WIDTH:0]   mem_q [TABLE_DEPTH];
    logic [KEY_WIDTH:0]   rd_data_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH:0]   wr_data;

    hkr_pkg::state_t      state_reg, state_next;
    hkr_pkg::req_t        op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]        scan_addr_reg, scan_addr_next;
    logic                 scan_done_reg, scan_done_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [AW-1:0]        chk_addr_reg, chk_addr_next;
    hkr_pkg::status_t     res_status_reg, res_status_next;
    logic [hkr_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic                 m_valid_reg, m_valid_next;
    hkr_pkg::status_t     m_status_reg, m_status_next;
    logic [hkr_pkg::SLOT_W-1:0] m_slot_reg, m_slot_next;

    hkr_pkg::req_t        in_req;
    logic [KEY_WIDTH-1:0] key_in;
    logic                 in_fire;
    logic                 out_free;
    logic                 tbl_full;
    logic                 tbl_empty;
    logic [HW-1:0]        hint_ext;
    logic [HW-1:0]        hint_lim;
    logic [AW-1:0]        start_addr;
    logic [AW-1:0]        last_addr;
    logic                 scan_hit;
    logic                 scan_end;
    logic                 prune_end;
    logic                 keep_it;

    generate
        if (KEY_WIDTH <= hkr_pkg::IN_KEY_W) begin : g_key_narrow
            assign key_in = s_item_key[KEY_WIDTH-1:0];
        end else begin : g_key_wide
            assign key_in = KEY_WIDTH'(s_item_key);
        end
    endgenerate

    assign in_req     = hkr_pkg::req_t'(s_req_type);
    assign s_ready    = (state_reg == hkr_pkg::S_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign tbl_full   = (count_reg == CW'(TABLE_DEPTH));
    assign tbl_empty  = (count_reg == '0);
    assign hint_ext   = HW'(s_slot_hint);
    assign hint_lim   = HW'(count_reg - CW'(1));
    assign start_addr = (hint_ext > hint_lim) ? AW'(hint_lim) : AW'(hint_ext);
    assign last_addr  = AW'(count_reg - CW'(1));
    assign scan_hit   = chk_vld_reg && rd_data_reg[KEY_WIDTH]
                        && (rd_data_reg[KEY_WIDTH-1:0] == key_reg);
    assign scan_end   = chk_vld_reg && (chk_addr_reg == '0);
    assign prune_end  = chk_vld_reg && (chk_addr_reg == last_addr);
    assign keep_it    = chk_vld_reg && rd_data_reg[KEY_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hkr_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (in_req)
                        hkr_pkg::REQ_ADD: state_next = hkr_pkg::S_FINISH;
                        hkr_pkg::REQ_PRUNE: begin
                            state_next = tbl_empty ? hkr_pkg::S_FINISH : hkr_pkg::S_PRUNE;
                        end
                        default: begin
                            state_next = tbl_empty ? hkr_pkg::S_FINISH : hkr_pkg::S_SCAN;
                        end
                    endcase
                end
            end
            hkr_pkg::S_SCAN: begin
                if (scan_hit || scan_end) begin
                    state_next = hkr_pkg::S_FINISH;
                end
            end
            hkr_pkg::S_PRUNE: begin
                if (prune_end) begin
                    state_next = hkr_pkg::S_FINISH;
                end
            end
            hkr_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = hkr_pkg::S_IDLE;
                end
            end
            default: state_next = hkr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        wr_ptr_next     = wr_ptr_reg;
        scan_addr_next  = scan_addr_reg;
        scan_done_next  = scan_done_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = chk_addr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        case (state_reg)
            hkr_pkg::S_IDLE: begin
                if (in_fire) begin
                    op_next         = in_req;
                    key_next        = key_in;
                    scan_done_next  = 1'b0;
                    wr_ptr_next     = '0;
                    res_status_next = hkr_pkg::ST_OK;
                    res_slot_next   = '0;
                    case (in_req)
                        hkr_pkg::REQ_ADD: begin
                            if (tbl_full) begin
                                res_status_next = hkr_pkg::ST_FULL;
                            end else begin
                                wr_en         = 1'b1;
                                wr_addr       = AW'(count_reg);
                                wr_data       = {1'b1, key_in};
                                count_next    = count_reg + CW'(1);
                                res_slot_next = hkr_pkg::SLOT_W'(count_reg);
                            end
                        end
                        hkr_pkg::REQ_PRUNE: begin
                            scan_addr_next = '0;
                        end
                        default: begin
                            if (tbl_empty) begin
                                res_status_next = hkr_pkg::ST_NOT_FOUND;
                            end
                            scan_addr_next = start_addr;
                        end
                    endcase
                end
            end
            hkr_pkg::S_SCAN: begin
                if (scan_hit) begin
                    res_status_next = hkr_pkg::ST_OK;
                    res_slot_next   = hkr_pkg::SLOT_W'(chk_addr_reg);
                    if (op_reg == hkr_pkg::REQ_REMOVE) begin
                        wr_en   = 1'b1;
                        wr_addr = chk_addr_reg;
                        wr_data = {1'b0, key_reg};
                    end
                end else if (scan_end) begin
                    res_status_next = hkr_pkg::ST_NOT_FOUND;
                    res_slot_next   = '0;
                end else begin
                    rd_en          = !scan_done_reg;
                    chk_vld_next   = !scan_done_reg;
                    chk_addr_next  = scan_addr_reg;
                    scan_addr_next = scan_addr_reg - AW'(1);
                    scan_done_next = scan_done_reg || (scan_addr_reg == '0);
                end
            end
            hkr_pkg::S_PRUNE: begin
                if (keep_it) begin
                    wr_en       = 1'b1;
                    wr_addr     = AW'(wr_ptr_reg);
                    wr_data     = {1'b1, rd_data_reg[KEY_WIDTH-1:0]};
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
                if (prune_end) begin
                    count_next      = wr_ptr_reg + CW'(keep_it);
                    res_status_next = hkr_pkg::ST_OK;
                    res_slot_next   = '0;
                end else begin
                    rd_en          = !scan_done_reg;
                    chk_vld_next   = !scan_done_reg;
                    chk_addr_next  = scan_addr_reg;
                    scan_addr_next = scan_addr_reg + AW'(1);
                    scan_done_next = scan_done_reg || (scan_addr_reg == last_addr);
                end
            end
            hkr_pkg::S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hkr_pkg::S_IDLE;
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            scan_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_vld_reg   <= chk_vld_next;
            scan_done_reg <= scan_done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        wr_ptr_reg     <= wr_ptr_next;
        scan_addr_reg  <= scan_addr_next;
        chk_addr_reg   <= chk_addr_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_reg;

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("slot count exceeds table depth");

    a_no_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same slot in one cycle");

    a_prune_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hkr_pkg::S_PRUNE && wr_en) |-> (wr_addr <= chk_addr_reg))
        else $error("compaction write overtook the read pointer");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_req == hkr_pkg::REQ_ADD && !tbl_full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("add did not grow the slot count");

endmodule
`default_nettype wire

### verif/hinted_key_registry_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hinted_key_registry_table_test
// Self-checking bench for the hinted key registry table. A driver pushes
// request beats from a backlog queue, and a monitor predicts each accepted
// request against its own copy of the table and checks every result beat in
// order. Directed corner cases come first, then random phases that fill,
// search, remove from and compact the table.
// ----------------------------------------------------------------------------
module hinted_key_registry_table_test;

    localparam int DEPTH        = hkr_pkg::TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TAIL_CYCLES  = DEPTH + 40;

    typedef struct packed {
        hkr_pkg::req_t                op;
        logic [hkr_pkg::IN_KEY_W-1:0] key;
        logic [hkr_pkg::HINT_W-1:0]   hint;
    } req_beat_t;

    typedef struct packed {
        hkr_pkg::status_t           st;
        logic [hkr_pkg::SLOT_W-1:0] slot;
    } reply_t;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_ADDS,
        PH_SEARCH,
        PH_MIXED
    } phase_kind_t;

    logic                         aclk;
    logic                         aresetn      = 1'b0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [hkr_pkg::REQ_W-1:0]    s_req_type   = hkr_pkg::REQ_ADD;
    logic [hkr_pkg::IN_KEY_W-1:0] s_item_key   = '0;
    logic [hkr_pkg::HINT_W-1:0]   s_slot_hint  = '0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [hkr_pkg::STATUS_W-1:0] m_status;
    logic [hkr_pkg::SLOT_W-1:0]   m_slot_index;

    req_beat_t                    req_backlog[$];
    reply_t                       due_results[$];
    bit                           beat_taken   = 1'b0;
    int                           idle_pct     = 33;
    int                           fail_count   = 0;
    int                           cycle_count  = 0;
    int                           rand_sent    = 0;

    logic [hkr_pkg::IN_KEY_W-1:0] tbl_key[DEPTH];
    bit   [DEPTH-1:0]             tbl_vld      = '0;
    int                           tbl_cnt      = 0;

    logic [hkr_pkg::IN_KEY_W-1:0] key_pool[$];
    int                           est_cnt      = 0;

    hinted_key_registry_table u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_item_key   (s_item_key),
        .s_slot_hint  (s_slot_hint),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_slot_index (m_slot_index)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void registry_apply(input hkr_pkg::req_t op,
                                           input logic [hkr_pkg::IN_KEY_W-1:0] key,
                                           input logic [hkr_pkg::HINT_W-1:0] hint,
                                           output hkr_pkg::status_t st,
                                           output logic [hkr_pkg::SLOT_W-1:0] slot);
        int  j;
        int  n;
        int  start;
        bit  hit;
        st   = hkr_pkg::ST_OK;
        slot = '0;
        case (op)
            hkr_pkg::REQ_ADD: begin
                if (tbl_cnt >= DEPTH) begin
                    st = hkr_pkg::ST_FULL;
                end else begin
                    slot = hkr_pkg::SLOT_W'(tbl_cnt);
                    tbl_key[tbl_cnt] = key;
                    tbl_vld[tbl_cnt] = 1'b1;
                    tbl_cnt++;
                end
            end
            hkr_pkg::REQ_LOOKUP, hkr_pkg::REQ_REMOVE: begin
                hit = 1'b0;
                if (tbl_cnt != 0) begin
                    start = (int'(hint) > tbl_cnt - 1) ? tbl_cnt - 1 : int'(hint);
                    for (j = start; j >= 0 && !hit; j--) begin
                        if (tbl_vld[j] && tbl_key[j] == key) begin
                            hit  = 1'b1;
                            slot = hkr_pkg::SLOT_W'(j);
                            if (op == hkr_pkg::REQ_REMOVE) tbl_vld[j] = 1'b0;
                        end
                    end
                end
                if (!hit) begin
                    st   = hkr_pkg::ST_NOT_FOUND;
                    slot = '0;
                end
            end
            default: begin
                n = 0;
                for (j = 0; j < tbl_cnt; j++) begin
                    if (tbl_vld[j]) begin
                        tbl_key[n] = tbl_key[j];
                        tbl_vld[n] = 1'b1;
                        n++;
                    end
                end
                for (j = n; j < DEPTH; j++) tbl_vld[j] = 1'b0;
                tbl_cnt = n;
            end
        endcase
    endfunction

    always @(negedge aclk) begin : drive_proc
        req_beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || beat_taken) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = req_backlog.pop_front();
                    s_valid     <= 1'b1;
                    s_req_type  <= nxt.op;
                    s_item_key  <= nxt.key;
                    s_slot_hint <= nxt.hint;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin : watch_proc
        hkr_pkg::status_t           st;
        logic [hkr_pkg::SLOT_W-1:0] sl;
        reply_t                     want;
        reply_t                     exp_rsp;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hinted_key_registry_table verification failed");
            $finish;
        end
        if (!aresetn) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                registry_apply(hkr_pkg::req_t'(s_req_type), s_item_key, s_slot_hint,
                               st, sl);
                exp_rsp.st   = st;
                exp_rsp.slot = sl;
                due_results.insert(due_results.size(), exp_rsp);
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result beat with no request outstanding: status %0d slot %0d",
                           m_status, m_slot_index);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (m_status !== want.st) begin
                        $error("status: expected %0d, actual %0d", want.st, m_status);
                        fail_count++;
                    end
                    if (m_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, m_slot_index);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic queue_req(input hkr_pkg::req_t op,
                             input logic [hkr_pkg::IN_KEY_W-1:0] key,
                             input logic [hkr_pkg::HINT_W-1:0] hint);
        req_beat_t rb;
        rb.op   = op;
        rb.key  = key;
        rb.hint = hint;
        req_backlog.insert(req_backlog.size(), rb);
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || s_valid || due_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [hkr_pkg::IN_KEY_W-1:0] search_key();
        int r;
        r = $urandom_range(0, 99);
        if (key_pool.size() != 0 && r < 75) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 88) return hkr_pkg::IN_KEY_W'($urandom_range(0, 31));
        return $urandom;
    endfunction

    function automatic logic [hkr_pkg::HINT_W-1:0] search_hint();
        int r;
        int top;
        r   = $urandom_range(0, 99);
        top = (est_cnt > 0) ? est_cnt - 1 : 0;
        if (top > 255) top = 255;
        if (r < 35) return hkr_pkg::HINT_W'($urandom_range(0, 255));
        if (r < 65) return hkr_pkg::HINT_W'($urandom_range(0, top));
        if (r < 85) return '1;
        return hkr_pkg::HINT_W'(top);
    endfunction

    task automatic issue_add();
        logic [hkr_pkg::IN_KEY_W-1:0] key;
        int                           r;
        r = $urandom_range(0, 99);
        if (r < 40) key = hkr_pkg::IN_KEY_W'($urandom_range(0, 31));
        else if (r < 50 && key_pool.size() != 0)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else key = $urandom;
        queue_req(hkr_pkg::REQ_ADD, key, hkr_pkg::HINT_W'($urandom_range(0, 255)));
        key_pool.insert(key_pool.size(), key);
        if (est_cnt < DEPTH) est_cnt++;
        rand_sent++;
    endtask

    task automatic issue_search(input hkr_pkg::req_t op);
        queue_req(op, search_key(), search_hint());
        rand_sent++;
    endtask

    task automatic issue_prune();
        queue_req(hkr_pkg::REQ_PRUNE, $urandom, hkr_pkg::HINT_W'($urandom_range(0, 255)));
        est_cnt = (key_pool.size() > DEPTH) ? DEPTH : key_pool.size();
        rand_sent++;
    endtask

    initial begin : stimulus
        int                           phase;
        int                           n_items;
        int                           i;
        int                           r;
        int                           idx;
        int                           w_add;
        int                           w_look;
        int                           w_rem;
        phase_kind_t                  kind;
        logic [hkr_pkg::IN_KEY_W-1:0] key;

        queue_req(hkr_pkg::REQ_LOOKUP, 32'h1234_5678, 8'h00);
        queue_req(hkr_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 8'hFF);
        queue_req(hkr_pkg::REQ_PRUNE,  32'h0000_0000, 8'h00);
        queue_req(hkr_pkg::REQ_ADD,    32'h0000_0000, 8'hFF);
        queue_req(hkr_pkg::REQ_ADD,    32'hFFFF_FFFF, 8'h00);
        queue_req(hkr_pkg::REQ_ADD,    32'hA5A5_A5A5, 8'h55);
        queue_req(hkr_pkg::REQ_ADD,    32'h0000_0000, 8'hAA);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'h0000_0000, 8'hFF);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'h0000_0000, 8'h02);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 8'h01);
        queue_req(hkr_pkg::REQ_REMOVE, 32'h0000_0000, 8'hFF);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'h0000_0000, 8'hFF);
        queue_req(hkr_pkg::REQ_REMOVE, 32'hA5A5_A5A5, 8'h02);
        queue_req(hkr_pkg::REQ_REMOVE, 32'hA5A5_A5A5, 8'h02);
        queue_req(hkr_pkg::REQ_PRUNE,  32'hFFFF_FFFF, 8'hFF);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 8'hFF);
        queue_req(hkr_pkg::REQ_ADD,    32'h5A5A_5A5A, 8'h00);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'h1234_5678, 8'h55);
        queue_req(hkr_pkg::REQ_ADD,    32'h8000_0001, 8'h80);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'h8000_0001, 8'hAA);
        queue_req(hkr_pkg::REQ_REMOVE, 32'h5A5A_5A5A, 8'h7F);
        queue_req(hkr_pkg::REQ_LOOKUP, 32'h5A5A_5A5A, 8'hFF);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        phase = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            wait_drained();
            key_pool.delete();
            for (i = 0; i < tbl_cnt; i++) begin
                if (tbl_vld[i]) key_pool.insert(key_pool.size(), tbl_key[i]);
            end
            est_cnt  = tbl_cnt;
            idle_pct = ($urandom_range(0, 9) == 0) ? 0 : 33;
            n_items  = $urandom_range(20, 80);

            r = $urandom_range(0, 99);
            if (phase == 1) begin
                kind     = PH_MIXED;
                idle_pct = 0;
                n_items  = 150;
            end else if (phase == 2 || r < 8) begin
                kind = PH_FILL;
            end else if (r < 22) begin
                kind = PH_DRAIN;
            end else if (r < 50 && est_cnt < 200) begin
                kind = PH_ADDS;
            end else if (r < 80) begin
                kind = PH_SEARCH;
            end else begin
                kind = PH_MIXED;
            end

            case (kind)
                PH_FILL: begin
                    n_items = DEPTH - est_cnt + $urandom_range(2, 5);
                    for (i = 0; i < n_items; i++) issue_add();
                    for (i = 0; i < 8; i++) issue_search(hkr_pkg::REQ_LOOKUP);
                    for (i = 0; i < 3; i++) issue_search(hkr_pkg::REQ_REMOVE);
                end
                PH_DRAIN: begin
                    if (n_items > key_pool.size()) n_items = key_pool.size();
                    for (i = 0; i < n_items; i++) begin
                        idx = $urandom_range(0, key_pool.size() - 1);
                        key = key_pool[idx];
                        key_pool.delete(idx);
                        queue_req(hkr_pkg::REQ_REMOVE, key,
                                  ($urandom_range(0, 99) < 70) ? 8'hFF : search_hint());
                        rand_sent++;
                    end
                    issue_prune();
                end
                default: begin
                    if (kind == PH_ADDS) begin
                        w_add = 60; w_look = 20; w_rem = 15;
                    end else if (kind == PH_SEARCH) begin
                        w_add = 20; w_look = 45; w_rem = 30;
                    end else begin
                        w_add = 30; w_look = 30; w_rem = 30;
                    end
                    for (i = 0; i < n_items; i++) begin
                        r = $urandom_range(0, 99);
                        if (r < w_add) issue_add();
                        else if (r < w_add + w_look) issue_search(hkr_pkg::REQ_LOOKUP);
                        else if (r < w_add + w_look + w_rem) issue_search(hkr_pkg::REQ_REMOVE);
                        else issue_prune();
                    end
                end
            endcase
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("hinted_key_registry_table verification clean");
        end else begin
            $display("hinted_key_registry_table verification failed");
        end
        $finish;
    end

endmodule
